### hdl/lpcg_pkg.sv
// ----------------------------------------------------------------------------
// lpcg_pkg: shared types and constants of the lidar polar-to-Cartesian gate
// Field widths, register indexes, reset values, the CORDIC arctangent table
// and the record that is handed along the rotation cells.
// ----------------------------------------------------------------------------
package lpcg_pkg;

	localparam int RangeW    = 16;
	localparam int BeamW     = 9;
	localparam int AngW      = 16;
	localparam int CfgDataW  = 16;
	localparam int CfgIdxW   = 8;
	localparam int CoordW    = 17;
	localparam int Stages    = 16;
	localparam int VecW      = 33;
	localparam int ZW        = 32;
	localparam int ExtraBits = 14;
	localparam int OutMax    = 65535;
	localparam int OutMin    = -65536;

	// Reciprocal of the CORDIC gain, scaled by 2^16.
	localparam logic [RangeW-1:0] GainInv = 16'd39797;

	// Shifts the angle by an eighth of a turn before the quadrant is taken.
	localparam logic [AngW-1:0] EighthTurn = 16'h2000;

	// Register indexes of the configuration port.
	localparam logic [CfgIdxW-1:0] RegStartAngle = 8'd0;
	localparam logic [CfgIdxW-1:0] RegAngleStep  = 8'd1;
	localparam logic [CfgIdxW-1:0] RegNearLimit  = 8'd2;
	localparam logic [CfgIdxW-1:0] RegFarLimit   = 8'd3;

	localparam logic [CfgDataW-1:0] StartAngleRst = 16'd0;
	localparam logic [CfgDataW-1:0] AngleStepRst  = 16'd182;
	localparam logic [CfgDataW-1:0] NearLimitRst  = 16'd410;
	localparam logic [CfgDataW-1:0] FarLimitRst   = 16'd3277;

	// Quadrant codes.
	localparam logic [1:0] QuadFirst  = 2'd0;
	localparam logic [1:0] QuadSecond = 2'd1;
	localparam logic [1:0] QuadThird  = 2'd2;
	localparam logic [1:0] QuadFourth = 2'd3;

	// atan(2^-i) with 2^32 units per turn.
	localparam logic [ZW-1:0] AtanTab [Stages] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
	};

	typedef logic signed [VecW-1:0] vec_t;
	typedef logic signed [ZW-1:0]   ang_acc_t;

	typedef struct packed {
		logic [CfgDataW-1:0] start_angle;
		logic [CfgDataW-1:0] angle_step;
		logic [CfgDataW-1:0] near_limit;
		logic [CfgDataW-1:0] far_limit;
	} lpcg_cfg_t;

	// One item in flight through the rotation chain.
	typedef struct packed {
		logic             vld;
		vec_t             x;
		vec_t             y;
		ang_acc_t         z;
		logic [1:0]       quad;
		logic [BeamW-1:0] beam;
	} lpcg_rot_t;

endpackage

### hdl/lpcg_in_if.sv
// ----------------------------------------------------------------------------
// lpcg_in_if: range sample channel
// Carries one range sample and its beam index per transfer.
// ----------------------------------------------------------------------------
interface lpcg_in_if;
	import lpcg_pkg::*;

	logic              valid;
	logic              ready;
	logic [RangeW-1:0] range_sample;
	logic [BeamW-1:0]  beam_index;

	modport source (output valid, range_sample, beam_index, input ready);
	modport sink (input valid, range_sample, beam_index, output ready);
endinterface

### hdl/lpcg_out_if.sv
// ----------------------------------------------------------------------------
// lpcg_out_if: Cartesian point channel
// Carries one gated point per transfer.
// ----------------------------------------------------------------------------
interface lpcg_out_if;
	import lpcg_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [CoordW-1:0] point_x;
	logic signed [CoordW-1:0] point_y;
	logic [BeamW-1:0]         point_beam;

	modport source (output valid, point_x, point_y, point_beam, input ready);
	modport sink (input valid, point_x, point_y, point_beam, output ready);
endinterface

### hdl/lpcg_cfg_if.sv
// ----------------------------------------------------------------------------
// lpcg_cfg_if: configuration write channel
// Carries a register index and the value to write per transfer.
// ----------------------------------------------------------------------------
interface lpcg_cfg_if;
	import lpcg_pkg::*;

	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hdl/lidar_polar_to_cartesian_gate_unit.sv
// ----------------------------------------------------------------------------
// lidar_polar_to_cartesian_gate_unit: gated polar-to-Cartesian conversion
// Latency: 19 register stages, the last of them the output register.
// Throughput: one sample per cycle unless the output stalls the 16-cell row.
// Reset clears every valid bit and loads the registers with their defaults.
// ----------------------------------------------------------------------------
//
// Each sample carries a range in unsigned Q4.12 metres and a beam index. The
// beam angle is start_angle + angle_step * beam_index in binary angle units
// (65536 per turn). The sample yields a point only if the beam index is below
// BEAMS and the range lies inside the inclusive window [near_limit, far_limit];
// otherwise it is taken and quietly dropped.
//
// Datapath, in order:
//   front stage 1  window check, beam angle
//   front stage 2  quadrant split, range times inverse CORDIC gain
//   16 cells       one CORDIC micro-rotation each, in Q4.26
//   back stage     quadrant rotation, rounding to Q4.12, saturation
//
// Every stage has its own valid bit and passes a ready back to the stage
// before it, so a bubble anywhere in the row is filled even while the output
// register holds a point that has not yet been taken.
//
// The configuration port is always ready. Writes to an index beyond the
// register list are ignored. The user must change registers only while the
// block is idle, which it does not enforce. They feed the first stage directly.
module lidar_polar_to_cartesian_gate_unit #(
	parameter int BEAMS = 360
) (
	input  logic       clk,
	input  logic       arst_n,
	lpcg_in_if.sink    sample,
	lpcg_out_if.source point,
	lpcg_cfg_if.sink   cfg
);
	import lpcg_pkg::*;

	lpcg_cfg_t cfg_q;

	// Link records and ready bits along the cell row.
	lpcg_rot_t          chain [Stages+1];
	logic [Stages:0]    rdy;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_angle <= StartAngleRst;
			cfg_q.angle_step  <= AngleStepRst;
			cfg_q.near_limit  <= NearLimitRst;
			cfg_q.far_limit   <= FarLimitRst;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				RegStartAngle: cfg_q.start_angle <= cfg.data;
				RegAngleStep:  cfg_q.angle_step  <= cfg.data;
				RegNearLimit:  cfg_q.near_limit  <= cfg.data;
				RegFarLimit:   cfg_q.far_limit   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Window check, beam angle and start vector.
	lpcg_front #(
		.BEAMS(BEAMS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_regs(cfg_q),
		.sample  (sample),
		.ready_i (rdy[0]),
		.rot_o   (chain[0])
	);

	// The rotation row: cell i shifts by i and adds or subtracts atan(2^-i).
	for (genvar i = 0; i < Stages; i++) begin : g_cell
		lpcg_cell #(
			.STAGE(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.rot_i  (chain[i]),
			.ready_o(rdy[i]),
			.ready_i(rdy[i+1]),
			.rot_o  (chain[i+1])
		);
	end

	// Quadrant rotation, rounding and the output register.
	lpcg_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rot_i  (chain[Stages]),
		.ready_o(rdy[Stages]),
		.point  (point)
	);
endmodule

### hdl/lpcg_front.sv
// ----------------------------------------------------------------------------
// lpcg_front: beam angle, range window and CORDIC start vector
// Two pipeline stages: the first gates the sample and forms the beam angle,
// the second splits off the quadrant and scales the range by the inverse gain.
// ----------------------------------------------------------------------------
module lpcg_front #(
	parameter int BEAMS = 360
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lpcg_pkg::lpcg_cfg_t cfg_regs,
	lpcg_in_if.sink             sample,
	input  logic                ready_i,
	output lpcg_pkg::lpcg_rot_t rot_o
);
	import lpcg_pkg::*;

	localparam int BeamCmpW = 13;
	localparam logic [BeamCmpW-1:0] BeamLimit = BeamCmpW'(BEAMS);

	logic                      vld_s1;
	logic [RangeW-1:0]         range_s1;
	logic [BeamW-1:0]          beam_s1;
	logic [AngW-1:0]           ang_s1;
	lpcg_rot_t                 rot_s2;

	logic                      rdy_s1;
	logic                      rdy_s2;
	logic                      acc;
	logic                      pass;
	logic [AngW+BeamW-1:0]     step_prod;
	logic [AngW-1:0]           ang_next;
	logic [AngW-1:0]           t_ang;
	logic [2*RangeW-1:0]       scaled;

	assign rdy_s2       = !rot_s2.vld || ready_i;
	assign rdy_s1       = !vld_s1 || rdy_s2;
	assign sample.ready = rdy_s1;
	assign acc          = sample.valid && rdy_s1;

	assign pass = ({{(BeamCmpW-BeamW){1'b0}}, sample.beam_index} < BeamLimit)
		&& (sample.range_sample >= cfg_regs.near_limit)
		&& (sample.range_sample <= cfg_regs.far_limit);

	assign step_prod = cfg_regs.angle_step * sample.beam_index;
	assign ang_next  = cfg_regs.start_angle + step_prod[AngW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= sample.valid && pass;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			range_s1 <= sample.range_sample;
			beam_s1  <= sample.beam_index;
			ang_s1   <= ang_next;
		end
	end

	assign t_ang  = ang_s1 + EighthTurn;
	assign scaled = range_s1 * GainInv;

	// The residual angle is the low 14 bits less an eighth turn, in 2^32 units.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_s2 <= '0;
		end else if (rdy_s2) begin
			rot_s2.vld <= vld_s1;
			if (vld_s1) begin
				rot_s2.x    <= signed'(VecW'(scaled[2*RangeW-1:2]));
				rot_s2.y    <= '0;
				rot_s2.z    <= {{3{~t_ang[13]}}, t_ang[12:0], 16'b0};
				rot_s2.quad <= t_ang[AngW-1:AngW-2];
				rot_s2.beam <= beam_s1;
			end
		end
	end

	assign rot_o = rot_s2;

`ifndef SYNTHESIS
	a_reject_drops: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !pass |=> !vld_s1)
		else $error("rejected sample entered the pipeline");
	a_pass_enters: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pass |=> vld_s1 && beam_s1 == $past(sample.beam_index))
		else $error("accepted sample lost at first stage");
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !rdy_s2 |=> vld_s1 && $stable(ang_s1))
		else $error("first stage changed while stalled");
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rot_s2.vld && !ready_i |=> rot_s2.vld && $stable(rot_s2.z))
		else $error("second stage changed while stalled");
`endif
endmodule

### hdl/lpcg_cell.sv
// ----------------------------------------------------------------------------
// lpcg_cell: one CORDIC rotation cell
// Rotates the vector by the fixed angle atan(2^-STAGE) towards zero residual.
// ----------------------------------------------------------------------------
module lpcg_cell #(
	parameter int STAGE = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lpcg_pkg::lpcg_rot_t rot_i,
	output logic                ready_o,
	input  logic                ready_i,
	output lpcg_pkg::lpcg_rot_t rot_o
);
	import lpcg_pkg::*;

	localparam ang_acc_t Step = signed'(AtanTab[STAGE]);

	lpcg_rot_t rot_q;
	vec_t      xi;
	vec_t      yi;
	ang_acc_t  zi;
	vec_t      dx;
	vec_t      dy;

	assign xi = rot_i.x;
	assign yi = rot_i.y;
	assign zi = rot_i.z;
	assign dx = yi >>> STAGE;
	assign dy = xi >>> STAGE;

	assign ready_o = !rot_q.vld || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q <= '0;
		end else if (ready_o) begin
			rot_q.vld <= rot_i.vld;
			if (rot_i.vld) begin
				if (!zi[ZW-1]) begin
					rot_q.x <= xi - dx;
					rot_q.y <= yi + dy;
					rot_q.z <= zi - Step;
				end else begin
					rot_q.x <= xi + dx;
					rot_q.y <= yi - dy;
					rot_q.z <= zi + Step;
				end
				rot_q.quad <= rot_i.quad;
				rot_q.beam <= rot_i.beam;
			end
		end
	end

	assign rot_o = rot_q;
endmodule

### hdl/lpcg_back.sv
// ----------------------------------------------------------------------------
// lpcg_back: quadrant rotation, rounding, saturation and output register
// Maps the rotated vector into its quadrant and drops the extra fraction bits.
// ----------------------------------------------------------------------------
module lpcg_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lpcg_pkg::lpcg_rot_t rot_i,
	output logic                ready_o,
	lpcg_out_if.source          point
);
	import lpcg_pkg::*;

	localparam int RW = VecW + 2 - ExtraBits;
	localparam logic signed [RW-1:0] SatHi = RW'(OutMax);
	localparam logic signed [RW-1:0] SatLo = RW'(OutMin);
	localparam logic signed [VecW+1:0] RoundHalf = (VecW+2)'(1 << (ExtraBits - 1));

	function automatic logic signed [CoordW-1:0] round_sat(input logic signed [VecW:0] v);
		logic signed [VecW+1:0] s;
		logic signed [RW-1:0]   r;
		s = {v[VecW], v} + RoundHalf;
		r = signed'(s[VecW+1:ExtraBits]);
		if (r > SatHi) begin
			r = SatHi;
		end else if (r < SatLo) begin
			r = SatLo;
		end
		return r[CoordW-1:0];
	endfunction

	logic                     vld_q;
	logic signed [CoordW-1:0] x_q;
	logic signed [CoordW-1:0] y_q;
	logic [BeamW-1:0]         beam_q;
	logic signed [VecW:0]     xe;
	logic signed [VecW:0]     ye;
	logic signed [VecW:0]     fx;
	logic signed [VecW:0]     fy;

	assign xe = {rot_i.x[VecW-1], rot_i.x};
	assign ye = {rot_i.y[VecW-1], rot_i.y};

	always_comb begin
		unique case (rot_i.quad)
			QuadFirst: begin
				fx = xe;
				fy = ye;
			end
			QuadSecond: begin
				fx = -ye;
				fy = xe;
			end
			QuadThird: begin
				fx = -xe;
				fy = -ye;
			end
			QuadFourth: begin
				fx = ye;
				fy = -xe;
			end
			default: begin
				fx = xe;
				fy = ye;
			end
		endcase
	end

	assign ready_o = !vld_q || point.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ready_o) begin
			vld_q <= rot_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && rot_i.vld) begin
			x_q    <= round_sat(fx);
			y_q    <= round_sat(fy);
			beam_q <= rot_i.beam;
		end
	end

	assign point.valid      = vld_q;
	assign point.point_x    = x_q;
	assign point.point_y    = y_q;
	assign point.point_beam = beam_q;
endmodule
